// ----- rtl/core/least_loaded_worker_select_top_defines.svh -----
// Assertion macros for the least-loaded worker select block.
`ifndef LEAST_LOADED_WORKER_SELECT_TOP_DEFINES_SVH
`define LEAST_LOADED_WORKER_SELECT_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define LLS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("least_loaded_worker_select: check failed");
// next-cycle implication, sampled on clk, off during reset
`define LLS_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("least_loaded_worker_select: check failed");
`else
`define LLS_ASSERT_IMP(name, ante, cons)
`define LLS_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ----- rtl/core/lls_pkg.sv -----
// Shared types, codes and the microcode program of the worker select block.
`timescale 1ns / 1ps

package lls_pkg;

	localparam int WORKER_W = 3;
	localparam int QLEN_W   = 16;
	localparam int SCORE_OW = 24;
	localparam int SEQ_W    = 32;
	localparam int DCNT_W   = $clog2(SEQ_W);
	localparam int PADDR_W  = 3;

	localparam logic [SCORE_OW-1:0] BEST_MAX = '1;

	// request type codes
	localparam logic [1:0] REQ_UPDATE = 2'd0;
	localparam logic [1:0] REQ_SELECT = 2'd1;
	localparam logic [1:0] REQ_FINISH = 2'd2;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [WORKER_W-1:0] worker_index;
		logic                worker_present;
		logic [QLEN_W-1:0]   queue_length;
	} req_t;

	typedef struct packed {
		logic [WORKER_W-1:0] picked_worker;
		logic                picked_valid;
		logic [SCORE_OW-1:0] pick_score;
	} rsp_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_RD_REQ,
		OP_WR_UPD,
		OP_WR_FIN,
		OP_SCAN_INIT,
		OP_SCAN_RD,
		OP_NOP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_PICK_INIT,
		OP_PICK_STEP,
		OP_RD_PICK,
		OP_WR_PICK,
		OP_RESP_PICK,
		OP_RESP_NONE
	} dp_op_t;

	typedef enum logic [2:0] {
		J_NEXT,
		J_GOTO,
		J_DISPATCH,
		J_LOOP_PTR,
		J_LOOP_DIV,
		J_IF_NONE
	} jmp_t;

	typedef logic [4:0] step_t;

	typedef struct packed {
		dp_op_t op;
		jmp_t   jmp;
		step_t  target;
	} uword_t;

	typedef struct packed {
		dp_op_t op;
		logic   accept;
	} ctrl_t;

	typedef struct packed {
		logic ptr_last;
		logic div_last;
		logic none;
	} stat_t;

	localparam step_t ST_IDLE      = 5'd0;
	localparam step_t ST_UPD_RD    = 5'd1;
	localparam step_t ST_UPD_WR    = 5'd2;
	localparam step_t ST_FIN_RD    = 5'd3;
	localparam step_t ST_FIN_WR    = 5'd4;
	localparam step_t ST_SCAN_INIT = 5'd5;
	localparam step_t ST_SCAN_RD   = 5'd6;
	localparam step_t ST_DRAIN0    = 5'd7;
	localparam step_t ST_DRAIN1    = 5'd8;
	localparam step_t ST_DIV_INIT  = 5'd9;
	localparam step_t ST_DIV_STEP  = 5'd10;
	localparam step_t ST_PICK_INIT = 5'd11;
	localparam step_t ST_PICK_STEP = 5'd12;
	localparam step_t ST_CNT_RD    = 5'd13;
	localparam step_t ST_CNT_WR    = 5'd14;
	localparam step_t ST_RESP_PICK = 5'd15;
	localparam step_t ST_RESP_NONE = 5'd16;

	// control store
	function automatic uword_t ucode(step_t s);
		uword_t w;
		unique case (s)
			ST_IDLE:      w = '{OP_IDLE,      J_DISPATCH, ST_IDLE};
			ST_UPD_RD:    w = '{OP_RD_REQ,    J_NEXT,     ST_IDLE};
			ST_UPD_WR:    w = '{OP_WR_UPD,    J_GOTO,     ST_RESP_NONE};
			ST_FIN_RD:    w = '{OP_RD_REQ,    J_NEXT,     ST_IDLE};
			ST_FIN_WR:    w = '{OP_WR_FIN,    J_GOTO,     ST_RESP_NONE};
			ST_SCAN_INIT: w = '{OP_SCAN_INIT, J_NEXT,     ST_IDLE};
			ST_SCAN_RD:   w = '{OP_SCAN_RD,   J_LOOP_PTR, ST_SCAN_RD};
			ST_DRAIN0:    w = '{OP_NOP,       J_NEXT,     ST_IDLE};
			ST_DRAIN1:    w = '{OP_NOP,       J_NEXT,     ST_IDLE};
			ST_DIV_INIT:  w = '{OP_DIV_INIT,  J_IF_NONE,  ST_RESP_NONE};
			ST_DIV_STEP:  w = '{OP_DIV_STEP,  J_LOOP_DIV, ST_DIV_STEP};
			ST_PICK_INIT: w = '{OP_PICK_INIT, J_NEXT,     ST_IDLE};
			ST_PICK_STEP: w = '{OP_PICK_STEP, J_LOOP_PTR, ST_PICK_STEP};
			ST_CNT_RD:    w = '{OP_RD_PICK,   J_NEXT,     ST_IDLE};
			ST_CNT_WR:    w = '{OP_WR_PICK,   J_NEXT,     ST_IDLE};
			ST_RESP_PICK: w = '{OP_RESP_PICK, J_GOTO,     ST_IDLE};
			ST_RESP_NONE: w = '{OP_RESP_NONE, J_GOTO,     ST_IDLE};
			default:      w = '{OP_IDLE,      J_GOTO,     ST_IDLE};
		endcase
		return w;
	endfunction

	// entry step of each request type
	function automatic step_t dispatch(logic [1:0] rt);
		step_t s;
		unique case (rt)
			REQ_UPDATE: s = ST_UPD_RD;
			REQ_SELECT: s = ST_SCAN_INIT;
			REQ_FINISH: s = ST_FIN_RD;
			default:    s = ST_RESP_NONE;
		endcase
		return s;
	endfunction

endpackage

// ----- rtl/core/lls_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/lls_useq.sv -----
// Microcode sequencer: step counter, control store and jump logic.
`timescale 1ns / 1ps

module lls_useq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    req_type,
	input  lls_pkg::stat_t stat,
	output lls_pkg::ctrl_t ctrl,
	output logic          busy
);

	import lls_pkg::*;

	step_t  pc_q;
	step_t  pc_d;
	uword_t uw;

	assign uw = ucode(pc_q);

	always_comb begin
		unique case (uw.jmp)
			J_NEXT:     pc_d = pc_q + step_t'(1);
			J_GOTO:     pc_d = uw.target;
			J_DISPATCH: pc_d = start ? dispatch(req_type) : pc_q;
			J_LOOP_PTR: pc_d = stat.ptr_last ? pc_q + step_t'(1) : uw.target;
			J_LOOP_DIV: pc_d = stat.div_last ? pc_q + step_t'(1) : uw.target;
			J_IF_NONE:  pc_d = stat.none ? uw.target : pc_q + step_t'(1);
			default:    pc_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.op     = uw.op;
		ctrl.accept = (pc_q == ST_IDLE) && start;
		busy        = (pc_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// ----- rtl/core/lls_dpath.sv -----
// Datapath: worker table, score pipeline, tie mask, remainder unit and pick scan.
`timescale 1ns / 1ps

module lls_dpath #(
	parameter int NUM_WORKERS = 8,
	parameter int COUNT_WIDTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lls_pkg::ctrl_t ctrl,
	input  lls_pkg::req_t  req,
	input  logic [7:0]     weight,
	output lls_pkg::stat_t stat,
	output logic           done,
	output lls_pkg::rsp_t  rsp
);

	import lls_pkg::*;

	localparam int AW      = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
	localparam int TIE_W   = $clog2(NUM_WORKERS + 1);
	localparam int PROD_W  = COUNT_WIDTH + 8;
	localparam int SCORE_W = ((PROD_W > QLEN_W) ? PROD_W : QLEN_W) + 1;
	localparam int ENTRY_W = 1 + QLEN_W + COUNT_WIDTH;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	req_t                   req_q;
	logic                   idx_ok_q;
	logic [AW-1:0]          ptr_q;
	logic [NUM_WORKERS-1:0] vld_q;
	logic                   rd_ok_s1;
	logic                   scan_s1;
	logic [AW-1:0]          idx_s1;
	logic                   scan_s2;
	logic                   pres_s2;
	logic [QLEN_W-1:0]      qlen_s2;
	logic [PROD_W-1:0]      prod_s2;
	logic [AW-1:0]          idx_s2;
	logic [SCORE_W-1:0]     best_q;
	logic [TIE_W-1:0]       ties_q;
	logic [NUM_WORKERS-1:0] mask_q;
	logic [SEQ_W-1:0]       dvd_q;
	logic [TIE_W-1:0]       rem_q;
	logic [DCNT_W-1:0]      dcnt_q;
	logic [TIE_W-1:0]       seen_q;
	logic [AW-1:0]          pick_q;
	logic [SEQ_W-1:0]       seq_q;

	logic                   we;
	logic [AW-1:0]          waddr;
	logic [ENTRY_W-1:0]     wdata;
	logic [AW-1:0]          raddr;
	logic [ENTRY_W-1:0]     rdata;
	logic [AW-1:0]          req_idx;
	logic                   rd_pres;
	logic [QLEN_W-1:0]      rd_qlen;
	logic [COUNT_WIDTH-1:0] rd_cnt;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [COUNT_WIDTH-1:0] cnt_dec;
	logic [SCORE_W-1:0]     score;
	logic [TIE_W:0]         div_try;
	logic [TIE_W:0]         ties_ext;

	assign req_idx = AW'(req_q.worker_index);

	// entries never written read as zero
	assign rd_pres = rd_ok_s1 & rdata[ENTRY_W-1];
	assign rd_qlen = rd_ok_s1 ? rdata[COUNT_WIDTH +: QLEN_W] : '0;
	assign rd_cnt  = rd_ok_s1 ? rdata[COUNT_WIDTH-1:0] : '0;
	assign cnt_inc = (rd_cnt != CNT_MAX) ? rd_cnt + COUNT_WIDTH'(1) : rd_cnt;
	assign cnt_dec = (rd_cnt != '0) ? rd_cnt - COUNT_WIDTH'(1) : rd_cnt;

	assign score    = SCORE_W'(prod_s2) + SCORE_W'(qlen_s2);
	assign div_try  = {rem_q, dvd_q[SEQ_W-1]};
	assign ties_ext = {1'b0, ties_q};

	always_comb begin
		raddr = req_idx;
		we    = 1'b0;
		waddr = req_idx;
		wdata = {rd_pres, rd_qlen, rd_cnt};
		unique case (ctrl.op)
			OP_SCAN_RD: raddr = ptr_q;
			OP_RD_PICK: raddr = pick_q;
			OP_WR_UPD: begin
				we    = idx_ok_q;
				wdata = {req_q.worker_present, req_q.queue_length, rd_cnt};
			end
			OP_WR_FIN: begin
				we    = idx_ok_q;
				wdata = {rd_pres, rd_qlen, cnt_dec};
			end
			OP_WR_PICK: begin
				we    = 1'b1;
				waddr = pick_q;
				wdata = {rd_pres, rd_qlen, cnt_inc};
			end
			default: ;
		endcase
	end

	lls_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_WORKERS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		stat.ptr_last = (ptr_q == AW'(NUM_WORKERS - 1));
		stat.div_last = (dcnt_q == '0);
		stat.none     = (ties_q == '0);
	end

	always_comb begin
		done = (ctrl.op == OP_RESP_PICK) || (ctrl.op == OP_RESP_NONE);
		rsp  = '0;
		if (ctrl.op == OP_RESP_PICK) begin
			rsp.picked_worker = WORKER_W'(pick_q);
			rsp.picked_valid  = 1'b1;
			rsp.pick_score    = (64'(best_q) > 64'(BEST_MAX)) ? BEST_MAX : SCORE_OW'(best_q);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			scan_s1 <= 1'b0;
			scan_s2 <= 1'b0;
			seq_q   <= '0;
			ptr_q   <= '0;
			ties_q  <= '0;
			dcnt_q  <= '0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			scan_s1 <= (ctrl.op == OP_SCAN_RD);
			scan_s2 <= scan_s1;
			case (ctrl.op) inside
				OP_SCAN_INIT, OP_PICK_INIT: ptr_q <= '0;
				OP_SCAN_RD, OP_PICK_STEP: begin
					if (!stat.ptr_last) begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				OP_DIV_INIT: dcnt_q <= DCNT_W'(SEQ_W - 1);
				OP_DIV_STEP: dcnt_q <= dcnt_q - DCNT_W'(1);
				OP_WR_PICK:  seq_q <= seq_q + SEQ_W'(1);
				default: ;
			endcase
			// running minimum over the scored workers
			if (ctrl.op == OP_SCAN_INIT) begin
				ties_q <= '0;
			end else if (scan_s2 && pres_s2) begin
				if (ties_q == '0 || score < best_q) begin
					ties_q <= TIE_W'(1);
				end else if (score == best_q) begin
					ties_q <= ties_q + TIE_W'(1);
				end
			end
		end
	end

	// payload and work registers
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			req_q    <= req;
			idx_ok_q <= (32'(req.worker_index) < NUM_WORKERS);
		end
		rd_ok_s1 <= vld_q[raddr];
		idx_s1   <= ptr_q;
		idx_s2   <= idx_s1;
		pres_s2  <= rd_pres;
		qlen_s2  <= rd_qlen;
		prod_s2  <= PROD_W'(rd_cnt) * PROD_W'(weight);
		if (ctrl.op == OP_SCAN_INIT) begin
			mask_q <= '0;
		end else if (scan_s2 && pres_s2) begin
			if (ties_q == '0 || score < best_q) begin
				best_q <= score;
				mask_q <= NUM_WORKERS'(1) << idx_s2;
			end else if (score == best_q) begin
				mask_q[idx_s2] <= 1'b1;
			end
		end
		case (ctrl.op)
			OP_DIV_INIT: begin
				dvd_q <= seq_q;
				rem_q <= '0;
			end
			// restoring remainder, one dividend bit per step
			OP_DIV_STEP: begin
				dvd_q <= {dvd_q[SEQ_W-2:0], 1'b0};
				rem_q <= (div_try >= ties_ext) ? TIE_W'(div_try - ties_ext) : TIE_W'(div_try);
			end
			OP_PICK_INIT: seen_q <= '0;
			OP_PICK_STEP: begin
				if (mask_q[ptr_q]) begin
					if (seen_q == rem_q) begin
						pick_q <= ptr_q;
					end
					seen_q <= seen_q + TIE_W'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/core/least_loaded_worker_select_top.sv -----
// Top level of the least-loaded worker select block.
`timescale 1ns / 1ps
`include "least_loaded_worker_select_top_defines.svh"

// Assigns connections to worker slots by least load with round-robin tie break.
// Request channel: a request is taken at a rising edge with start high and busy
// low; busy stays high until its result has been shown. Result channel: done is
// high for exactly one cycle with rsp valid; it cannot be held off. Every
// request yields one result, the next request is taken from the cycle after it.
// A select scans the worker table (score pass) and, if a worker is present, runs
// a 32-step remainder loop on the select sequence, one dividend bit per step,
// then walks the tie mask (pick pass) and raises the picked worker's count; the
// sequencer handles one request at a time.
// inflight_weight is written over the APB port at byte address 0 (only paddr[2]
// is decoded); the user must write it only while idle, the block itself does
// not enforce this.
// Reset clears all worker entries, the sequence and sets the weight to 8; no
// clearing pass is needed, the block takes requests right after reset.
module least_loaded_worker_select_top #(
	parameter int NUM_WORKERS = 8,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  lls_pkg::req_t                req,
	output logic                         done,
	output lls_pkg::rsp_t                rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lls_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	import lls_pkg::*;

	localparam logic REG_INFLIGHT_WEIGHT = 1'b0;
	localparam logic [7:0] WEIGHT_RST = 8'd8;

	logic [7:0] weight_q;
	ctrl_t      ctrl;
	stat_t      stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_INFLIGHT_WEIGHT) ? {24'd0, weight_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RST;
		end else if (psel && penable && pwrite && paddr[2] == REG_INFLIGHT_WEIGHT) begin
			weight_q <= pwdata[7:0];
		end
	end

	lls_useq u_useq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_type(req.req_type),
		.stat    (stat),
		.ctrl    (ctrl),
		.busy    (busy)
	);

	lls_dpath #(
		.NUM_WORKERS(NUM_WORKERS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_dpath (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.req   (req),
		.weight(weight_q),
		.stat  (stat),
		.done  (done),
		.rsp   (rsp)
	);

	`LLS_ASSERT_IMP(a_done_while_busy, done, busy)
	`LLS_ASSERT_NXT(a_accept_sets_busy, start && !busy, busy)
	`LLS_ASSERT_NXT(a_done_releases, done, !done && !busy)
	`LLS_ASSERT_IMP(a_none_zero, done && !rsp.picked_valid, {rsp.picked_worker, rsp.pick_score} == '0)

endmodule

// ----- verif/lls_checker.sv -----
// Checker for the worker select block: predicts each result from the requests and compares.
`timescale 1ns / 1ps

module lls_checker #(
	parameter int NUM_WORKERS = 8,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  lls_pkg::req_t                req,
	input  logic                         done,
	input  lls_pkg::rsp_t                rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lls_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	input  logic                         pready,
	output int                           fail_count,
	output int                           pending
);
	import lls_pkg::*;

	localparam logic [PADDR_W-1:0] WEIGHT_ADDR = '0;
	localparam logic [7:0]         WEIGHT_RESET = 8'd8;

	logic                   present [NUM_WORKERS];
	logic [QLEN_W-1:0]      qlen [NUM_WORKERS];
	logic [COUNT_WIDTH-1:0] inflight [NUM_WORKERS];
	logic [SEQ_W-1:0]       select_seq;
	logic [7:0]             weight;

	rsp_t pick_q [$];

	function automatic logic [63:0] load_score(int w);
		logic [63:0] cnt;
		cnt = 64'(inflight[w]);
		return cnt * 64'(weight) + 64'(qlen[w]);
	endfunction

	task automatic serve_request(input req_t r, output rsp_t o);
		logic [63:0] best;
		logic [63:0] s;
		int unsigned ties;
		int unsigned pos;
		int unsigned seen;
		int pick;
		o = '0;
		case (r.req_type)
			REQ_UPDATE: begin
				if (r.worker_index < NUM_WORKERS) begin
					present[r.worker_index] = r.worker_present;
					qlen[r.worker_index] = r.queue_length;
				end
			end
			REQ_FINISH: begin
				if (r.worker_index < NUM_WORKERS && inflight[r.worker_index] != '0)
					inflight[r.worker_index] = inflight[r.worker_index] - COUNT_WIDTH'(1);
			end
			REQ_SELECT: begin
				best = '0;
				ties = 0;
				for (int w = 0; w < NUM_WORKERS; w++) begin
					if (present[w]) begin
						s = load_score(w);
						if (ties == 0 || s < best) begin
							best = s;
							ties = 1;
						end else if (s == best) begin
							ties++;
						end
					end
				end
				if (ties > 0) begin
					pos = select_seq % ties;
					seen = 0;
					pick = 0;
					// count the tied workers, then walk them in index order and take the one at pos
					for (int w = NUM_WORKERS - 1; w >= 0; w--) begin
						if (present[w] && load_score(w) == best)
							seen++;
					end
					seen = 0;
					for (int w = 0; w < NUM_WORKERS; w++) begin
						if (present[w] && load_score(w) == best) begin
							if (seen == pos)
								pick = w;
							seen++;
						end
					end
					select_seq = select_seq + SEQ_W'(1);
					if (inflight[pick] != '1)
						inflight[pick] = inflight[pick] + COUNT_WIDTH'(1);
					o.picked_worker = WORKER_W'(pick);
					o.picked_valid = 1'b1;
					o.pick_score = (best > 64'(BEST_MAX)) ? BEST_MAX : best[SCORE_OW-1:0];
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t got;
		if (!arst_n) begin
			for (int w = 0; w < NUM_WORKERS; w++) begin
				present[w] = 1'b0;
				qlen[w] = '0;
				inflight[w] = '0;
			end
			select_seq = '0;
			weight = WEIGHT_RESET;
			pick_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == WEIGHT_ADDR[2])
				weight = pwdata[7:0];
			if (done) begin
				got = rsp;
				if (pick_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: worker %0d valid %0d score %0d",
							got.picked_worker, got.picked_valid, got.pick_score);
				end else begin
					want = pick_q.pop_front();
					if (got.picked_worker != want.picked_worker ||
							got.picked_valid != want.picked_valid ||
							got.pick_score != want.pick_score) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: worker %0d/%0d valid %0d/%0d score %0d/%0d (exp/got)",
								want.picked_worker, got.picked_worker,
								want.picked_valid, got.picked_valid,
								want.pick_score, got.pick_score);
					end
				end
			end
			if (start && !busy) begin
				serve_request(req, want);
				pick_q.insert(pick_q.size(), want);
			end
			pending = pick_q.size();
		end
	end

endmodule

// ----- verif/tb_least_loaded_worker_select_top.sv -----
// Testbench top for the worker select block: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_least_loaded_worker_select_top;
	import lls_pkg::*;

	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam logic [PADDR_W-1:0] WEIGHT_ADDR = '0;
	localparam int CYCLE_LIMIT = 400000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	req_t                req = '0;
	logic                done;
	rsp_t                rsp;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	int fail_count;
	int pending;
	int cycles = 0;
	bit gaps_on = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	least_loaded_worker_select_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	lls_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic req_t make_req(logic [1:0] t, int idx, logic pres, logic [15:0] q);
		req_t r;
		r.req_type = t;
		r.worker_index = WORKER_W'(idx);
		r.worker_present = pres;
		r.queue_length = q;
		return r;
	endfunction

	// mostly small queue lengths so that scores tie often
	function automatic req_t random_request();
		req_t r;
		int roll;
		int qroll;
		roll = $urandom_range(0, 99);
		qroll = $urandom_range(0, 9);
		if (roll < 35)
			r.req_type = REQ_UPDATE;
		else if (roll < 75)
			r.req_type = REQ_SELECT;
		else if (roll < 95)
			r.req_type = REQ_FINISH;
		else
			r.req_type = REQ_SPARE;
		r.worker_index = WORKER_W'($urandom_range(0, 7));
		r.worker_present = ($urandom_range(0, 4) != 0);
		if (qroll < 6)
			r.queue_length = 16'($urandom_range(0, 15));
		else if (qroll < 8)
			r.queue_length = 16'($urandom);
		else if (qroll == 8)
			r.queue_length = 16'hFFFF;
		else
			r.queue_length = '0;
		return r;
	endfunction

	// hold the request until it is taken, then maybe idle a while
	task automatic send(input req_t r);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_weight(input logic [7:0] w);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= WEIGHT_ADDR;
		pwdata <= {24'h0, w};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_run(input int n);
		for (int i = 0; i < n; i++)
			send(random_request());
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nobody present, unused type, finish at zero
		send(make_req(REQ_SELECT, 0, 1'b0, 16'h0));
		send(make_req(REQ_SPARE, 7, 1'b1, 16'hFFFF));
		send(make_req(REQ_FINISH, 0, 1'b0, 16'h0));
		// three tied workers, rotate through them
		send(make_req(REQ_UPDATE, 0, 1'b1, 16'h0));
		send(make_req(REQ_UPDATE, 7, 1'b1, 16'h0));
		send(make_req(REQ_UPDATE, 3, 1'b1, 16'h0));
		repeat (4) send(make_req(REQ_SELECT, 0, 1'b0, 16'h0));
		send(make_req(REQ_UPDATE, 5, 1'b1, 16'hFFFF));
		send(make_req(REQ_UPDATE, 5, 1'b0, 16'h5555));
		send(make_req(REQ_UPDATE, 2, 1'b1, 16'hAAAA));
		repeat (3) send(make_req(REQ_FINISH, 0, 1'b1, 16'hFFFF));
		repeat (2) send(make_req(REQ_SELECT, 7, 1'b1, 16'hFFFF));
		send(make_req(REQ_UPDATE, 7, 1'b0, 16'hFFFF));
		send(make_req(REQ_SELECT, 0, 1'b0, 16'h0));
		send(make_req(REQ_FINISH, 7, 1'b0, 16'h0));

		write_weight(8'd0);
		random_run(100);
		write_weight(8'd255);
		random_run(100);
		write_weight(8'd1);
		random_run(100);
		write_weight(8'($urandom_range(2, 254)));
		random_run(100);
		write_weight(8'd8);
		gaps_on = 1'b0;
		random_run(100);

		wait_drained();
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
